FILE: src/srq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_pkg: shared types and codes for the sorted record queue
// Record layout, transaction payloads, opcodes and status codes.
// ----------------------------------------------------------------------------
package srq_pkg;

    // Opcodes of an input transaction.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Status codes of a result transaction.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // One stored record. The sort key is {name_head, name_last}.
    typedef struct packed {
        logic [63:0]        name_head;
        logic [7:0]         name_last;
        logic [7:0]         age;
        logic signed [31:0] phone;
    } rec_t;

    // Input transaction payload.
    typedef struct packed {
        logic               opcode;
        logic [63:0]        name_head;
        logic [7:0]         name_last;
        logic [7:0]         age;
        logic signed [31:0] phone;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         count;
        logic               head_valid;
        logic [63:0]        head_name_first;
        logic [7:0]         head_name_ninth;
        logic [7:0]         head_age;
        logic signed [31:0] head_phone;
    } out_item_t;

    // Write request from the sequencer to the record store.
    typedef struct packed {
        logic en;
        rec_t data;
    } mem_wr_t;

endpackage

FILE: src/srq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_store: record memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 aclk,
    input  srq_pkg::mem_wr_t     wr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [AW-1:0]        rd_addr,
    output srq_pkg::rec_t        rd_data
);

    srq_pkg::rec_t mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
    end

    // Read port, data registered.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/srq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_ctrl: insertion sequencer
// Keeps the queue as a ring in the record store and walks it one record at a
// time with a single key comparator, shifting larger records toward the tail.
// ----------------------------------------------------------------------------
module srq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  srq_pkg::in_item_t     in_item,
    input  logic                  res_free,
    output logic                  res_load,
    output srq_pkg::out_item_t    res_item,
    output srq_pkg::mem_wr_t      wr,
    output logic [AW-1:0]         wr_addr,
    output logic [AW-1:0]         rd_addr,
    input  srq_pkg::rec_t         rd_data,
    output logic [CW-1:0]         count
);

    localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SCAN_RD  = 5'b00010,
        ST_SCAN_CMP = 5'b00100,
        ST_HEAD_RD  = 5'b01000,
        ST_HEAD_CAP = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [1:0]         status_reg, status_next;
    srq_pkg::in_item_t  item_reg, item_next;
    srq_pkg::rec_t      new_rec;
    logic               held_greater;

    // Ring position of a queue offset.
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    // The record carried by the pending insert.
    assign new_rec.name_head = item_reg.name_head;
    assign new_rec.name_last = item_reg.name_last;
    assign new_rec.age       = item_reg.age;
    assign new_rec.phone     = item_reg.phone;

    // Shared comparator: held key strictly greater than the new key.
    assign held_greater = {rd_data.name_head, rd_data.name_last} >
                          {item_reg.name_head, item_reg.name_last};

    assign in_ready = (state_reg == ST_IDLE);
    assign count    = count_reg;
    assign wr_addr  = ring_addr(head_reg, pos_reg);

    // The head is read in the final two states; otherwise the record in
    // front of the current insert position.
    assign rd_addr = (state_reg == ST_HEAD_RD || state_reg == ST_HEAD_CAP) ?
                     head_reg : ring_addr(head_reg, pos_reg - AW'(1));

    // Result as seen after the step; an empty queue reports zeros.
    always_comb begin
        res_item.status     = status_reg;
        res_item.count      = 5'(count_reg);
        res_item.head_valid = (count_reg != '0);
        if (count_reg != '0) begin
            res_item.head_name_first = rd_data.name_head;
            res_item.head_name_ninth = rd_data.name_last;
            res_item.head_age        = rd_data.age;
            res_item.head_phone      = rd_data.phone;
        end else begin
            res_item.head_name_first = '0;
            res_item.head_name_ninth = '0;
            res_item.head_age        = '0;
            res_item.head_phone      = '0;
        end
    end

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        item_next   = item_reg;
        wr.en       = 1'b0;
        wr.data     = new_rec;
        res_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next = in_item;
                    if (in_item.opcode == srq_pkg::OP_INSERT) begin
                        if (count_reg == DEPTH_C) begin
                            status_next = srq_pkg::STATUS_FULL;
                            state_next  = ST_HEAD_RD;
                        end else begin
                            status_next = srq_pkg::STATUS_DONE;
                            pos_next    = AW'(count_reg);
                            state_next  = ST_SCAN_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = srq_pkg::STATUS_EMPTY;
                        end else begin
                            status_next = srq_pkg::STATUS_DONE;
                            head_next   = ring_addr(head_reg, AW'(1));
                            count_next  = count_reg - CW'(1);
                        end
                        state_next = ST_HEAD_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                // At the head: the new record goes in front of everything.
                if (pos_reg == '0) begin
                    wr.en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = ST_HEAD_RD;
                end else begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (held_greater) begin
                    wr.en      = 1'b1;
                    wr.data    = rd_data;
                    pos_next   = pos_reg - AW'(1);
                    state_next = ST_SCAN_RD;
                end else begin
                    wr.en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                state_next = ST_HEAD_CAP;
            end
            ST_HEAD_CAP: begin
                if (res_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
        end
    end

    // Working payload.
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        status_reg <= status_next;
        item_reg   <= item_next;
    end

endmodule

FILE: src/sorted_record_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_queue_top: bounded queue of records sorted by name
// Insert keeps ascending name order with equal names in arrival order; pop
// removes the head. Every transaction returns one result with the head.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one transaction (insert or pop) when s_valid and
//   s_ready are both high; s_ready is low while a transaction is in work.
//   The m_ channel gives exactly one result per input transaction: status,
//   count after the step and the current head record.
//   A pop or a refused insert goes from acceptance straight to the head read
//   and the result. An insert compares held records from the tail toward the
//   head, one at a time with one key comparator and one memory read port,
//   moving each larger record one place toward the tail, and stops behind a
//   smaller or equal name or becomes the new head. The next transaction can
//   be accepted in the cycle after the result is loaded.
//   The result sits in an output register, so a new transaction is accepted
//   while an earlier result still waits; if the receiver stalls longer, the
//   next result waits in the sequencer until the output register frees up.
//   Reset (aresetn low, synchronous) empties the queue; record memory is not
//   cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_record_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  srq_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output srq_pkg::out_item_t   m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    srq_pkg::mem_wr_t    wr;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    srq_pkg::rec_t       rd_data;
    logic                res_free;
    logic                res_load;
    srq_pkg::out_item_t  res_item;
    logic [CW-1:0]       count;
    logic                m_valid_reg;
    srq_pkg::out_item_t  m_data_reg;

    srq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (s_data),
        .res_free (res_free),
        .res_load (res_load),
        .res_item (res_item),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .count    (count)
    );

    srq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register between the sequencer and the result channel.
    assign res_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The held count never exceeds the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(DEPTH))
        else $error("record count above capacity");

    // A loaded result reports a head exactly when records are held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (res_item.head_valid == (count != '0)))
        else $error("head_valid disagrees with count");

    // A result is only loaded into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> res_free)
        else $error("result overwrote a pending transaction");

    // The sequencer does not take a second transaction right after one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("transaction accepted while busy");

endmodule
